@@ design/rmcp_pkg.sv @@
// Shared types, codes and helpers for the RTP-MIDI command section parser.
package rmcp_pkg;

    localparam int SYSEX_MAX = 128;
    localparam int COUNT_W   = 13;
    localparam int REM_W     = 12;
    localparam int POS_W     = 16;

    localparam logic [1:0] KIND_SHORT = 2'd0;
    localparam logic [1:0] KIND_SYSEX = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_UNDEF   = 2'd1;
    localparam logic [1:0] ERR_OVERRUN = 2'd2;

    // message length codes from msg_length()
    localparam logic [2:0] LEN_UNDEF = 3'd0;
    localparam logic [2:0] LEN_ONE   = 3'd1;
    localparam logic [2:0] LEN_TWO   = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_SYSEX = 3'd4;

    localparam logic [7:0] SYSEX_START = 8'hF0;
    localparam logic [7:0] SYSEX_END   = 8'hF7;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_LENLO,
        PH_DELTA,
        PH_STATUS,
        PH_DATA,
        PH_SYSEX,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       packet_start;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         msg_type;
        logic [4:0]         channel;
        logic [7:0]         first_data;
        logic [7:0]         second_data;
        logic [COUNT_W-1:0] byte_count;
        logic [31:0]        timestamp;
        logic [7:0]         sysex_byte;
        logic               last;
        logic [1:0]         error_code;
    } out_item_t;

    function automatic logic [2:0] msg_length(input logic [7:0] s);
        logic [2:0] len;
        len = LEN_UNDEF;
        if (s[7:4] == 4'hF) begin
            unique case (s[3:0])
                4'h0:                               len = LEN_SYSEX;
                4'h1, 4'h3:                         len = LEN_TWO;
                4'h2:                               len = LEN_THREE;
                4'h6, 4'h8, 4'hA, 4'hB, 4'hC,
                4'hE, 4'hF:                         len = LEN_ONE;
                default:                            len = LEN_UNDEF;
            endcase
        end
        else if (s[7]) begin
            len = (s[7:4] == 4'hC || s[7:4] == 4'hD) ? LEN_TWO : LEN_THREE;
        end
        return len;
    endfunction

endpackage

@@ design/rmcp_in_stage.sv @@
// Input register stage: holds one accepted byte until the parser takes it.
module rmcp_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rmcp_pkg::in_item_t in_item,
    output logic               item_valid,
    output rmcp_pkg::in_item_t item,
    input  logic               item_take
);
    import rmcp_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign in_ready   = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (item_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

@@ design/rmcp_parser.sv @@
// Packet parse state and the single-pass byte decode.
module rmcp_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_data,
    input  logic                item_valid,
    input  rmcp_pkg::in_item_t  item,
    output logic                item_take,
    input  logic                slot_free,
    output logic                res_valid,
    output rmcp_pkg::out_item_t res
);
    import rmcp_pkg::*;

    logic [7:0]         offset_reg;
    logic [POS_W-1:0]   pos_reg, pos_next, pos_c;
    logic [31:0]        time_reg, time_next, time_c;
    logic               z_reg, z_next, z_c;
    logic [REM_W-1:0]   rem_reg, rem_next, rem_c, rem_dec;
    phase_t             phase_reg, phase_next, phase_c;
    logic [7:0]         held_status_reg, held_status_next, held_status_c;
    logic [7:0]         held_data_reg, held_data_next, held_data_c;
    logic [1:0]         wanted_reg, wanted_next, wanted_c;
    logic [2:0]         delta_reg, delta_next, delta_c, delta_inc;
    logic [COUNT_W-1:0] count_reg, count_next, count_c, count_inc;
    logic [7:0]         b;
    logic               start;
    logic [2:0]         len_b, len_h;
    logic               sx_last;
    logic [3:0]         hdr_len;

    function automatic out_item_t make_short(input logic [7:0] s, input logic [1:0] len,
                                             input logic [7:0] d1, input logic [7:0] d2);
        out_item_t r;
        r = '0;
        r.kind        = KIND_SHORT;
        r.msg_type    = (s[7:4] != 4'hF) ? {s[7:4], 4'h0} : s;
        r.channel     = (s[7:4] != 4'hF) ? 5'({1'b0, s[3:0]} + 5'd1) : 5'd0;
        r.first_data  = d1;
        r.second_data = d2;
        r.byte_count  = COUNT_W'(len);
        r.error_code  = ERR_NONE;
        return r;
    endfunction

    function automatic out_item_t make_error(input logic [1:0] code);
        out_item_t r;
        r = '0;
        r.kind       = KIND_ERROR;
        r.error_code = code;
        return r;
    endfunction

    assign b         = item.data_byte;
    assign start     = item.packet_start;
    assign item_take = item_valid && slot_free;

    always_comb
    begin
        // a packet start wipes the parse state before the byte is looked at
        pos_c         = start ? '0 : pos_reg;
        time_c        = start ? '0 : time_reg;
        z_c           = start ? 1'b0 : z_reg;
        rem_c         = start ? '0 : rem_reg;
        phase_c       = start ? PH_HEADER : phase_reg;
        held_status_c = start ? '0 : held_status_reg;
        held_data_c   = start ? '0 : held_data_reg;
        wanted_c      = start ? '0 : wanted_reg;
        delta_c       = start ? '0 : delta_reg;
        count_c       = start ? '0 : count_reg;

        rem_dec   = rem_c - REM_W'(1);
        delta_inc = delta_c + 3'd1;
        len_b     = msg_length(b);
        len_h     = msg_length(held_status_c);
        hdr_len   = b[3:0];
        // a sysex opened from status position restarts the count
        count_inc = ((phase_c == PH_SYSEX) ? count_c : '0) + COUNT_W'(1);
        sx_last   = (b == SYSEX_END && count_inc > COUNT_W'(1)) ||
                    count_inc >= COUNT_W'(SYSEX_MAX) || rem_dec == '0;

        pos_next         = pos_reg;
        time_next        = time_reg;
        z_next           = z_reg;
        rem_next         = rem_reg;
        phase_next       = phase_reg;
        held_status_next = held_status_reg;
        held_data_next   = held_data_reg;
        wanted_next      = wanted_reg;
        delta_next       = delta_reg;
        count_next       = count_reg;
        res_valid        = 1'b0;
        res              = '0;

        if (item_take && phase_c != PH_IDLE)
        begin
            pos_next         = (&pos_c) ? pos_c : pos_c + POS_W'(1);
            time_next        = (pos_c[POS_W-1:2] == (POS_W-2)'(1)) ?
                               {time_c[23:0], b} : time_c;
            z_next           = z_c;
            rem_next         = rem_c;
            phase_next       = phase_c;
            held_status_next = held_status_c;
            held_data_next   = held_data_c;
            wanted_next      = wanted_c;
            delta_next       = delta_c;
            count_next       = count_c;

            unique case (phase_c)
                PH_HEADER:
                begin
                    if (pos_c == {8'h00, offset_reg})
                    begin
                        z_next     = b[5];
                        rem_next   = REM_W'(hdr_len);
                        delta_next = '0;
                        if (b[7])
                            phase_next = PH_LENLO;
                        else if (hdr_len == 4'd0)
                            phase_next = PH_DONE;
                        else
                            phase_next = b[5] ? PH_DELTA : PH_STATUS;
                    end
                end
                PH_LENLO:
                begin
                    rem_next   = {rem_c[3:0], b};
                    delta_next = '0;
                    if ({rem_c[3:0], b} == '0)
                        phase_next = PH_DONE;
                    else
                        phase_next = z_c ? PH_DELTA : PH_STATUS;
                end
                PH_DONE, PH_IDLE:
                begin
                end
                default:
                begin
                    if (rem_c == '0)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        rem_next = rem_dec;
                        unique case (phase_c)
                            PH_DELTA:
                            begin
                                delta_next = delta_inc;
                                if (!b[7] || delta_inc >= 3'd4)
                                begin
                                    phase_next = (rem_dec == '0) ? PH_DONE : PH_STATUS;
                                end
                                else if (rem_dec == '0)
                                begin
                                    phase_next = PH_DONE;
                                    res_valid  = 1'b1;
                                    res        = make_error(ERR_OVERRUN);
                                end
                            end
                            PH_STATUS:
                            begin
                                unique case (len_b)
                                    LEN_UNDEF:
                                    begin
                                        phase_next = PH_DONE;
                                        res_valid  = 1'b1;
                                        res        = make_error(ERR_UNDEF);
                                    end
                                    LEN_ONE:
                                    begin
                                        res_valid  = 1'b1;
                                        res        = make_short(b, 2'd1, 8'h00, 8'h00);
                                        delta_next = '0;
                                        phase_next = (rem_dec == '0) ? PH_DONE : PH_DELTA;
                                    end
                                    LEN_SYSEX:
                                    begin
                                        count_next = count_inc;
                                        res_valid  = 1'b1;
                                        res.kind        = KIND_SYSEX;
                                        res.msg_type    = SYSEX_START;
                                        res.first_data  = count_inc[7:0];
                                        res.second_data = 8'(count_inc[COUNT_W-1:8]);
                                        res.byte_count  = count_inc;
                                        res.sysex_byte  = b;
                                        res.last        = sx_last;
                                        if (sx_last)
                                        begin
                                            delta_next = '0;
                                            phase_next = (rem_dec == '0) ? PH_DONE : PH_DELTA;
                                        end
                                        else
                                        begin
                                            phase_next = PH_SYSEX;
                                        end
                                    end
                                    default:
                                    begin
                                        if (rem_dec == '0)
                                        begin
                                            phase_next = PH_DONE;
                                            res_valid  = 1'b1;
                                            res        = make_error(ERR_OVERRUN);
                                        end
                                        else
                                        begin
                                            held_status_next = b;
                                            wanted_next      = 2'(len_b - 3'd1);
                                            phase_next       = PH_DATA;
                                        end
                                    end
                                endcase
                            end
                            PH_DATA:
                            begin
                                if (len_h == LEN_THREE && wanted_c == 2'd2)
                                begin
                                    held_data_next = b;
                                    wanted_next    = 2'd1;
                                    if (rem_dec == '0)
                                    begin
                                        phase_next = PH_DONE;
                                        res_valid  = 1'b1;
                                        res        = make_error(ERR_OVERRUN);
                                    end
                                end
                                else
                                begin
                                    wanted_next = 2'd0;
                                    res_valid   = 1'b1;
                                    if (len_h == LEN_THREE)
                                        res = make_short(held_status_c, 2'd3, held_data_c, b);
                                    else
                                        res = make_short(held_status_c, 2'd2, b, 8'h00);
                                    delta_next  = '0;
                                    phase_next  = (rem_dec == '0) ? PH_DONE : PH_DELTA;
                                end
                            end
                            default:
                            begin
                                // sysex continuation byte
                                count_next = count_inc;
                                res_valid  = 1'b1;
                                res.kind        = KIND_SYSEX;
                                res.msg_type    = SYSEX_START;
                                res.first_data  = count_inc[7:0];
                                res.second_data = 8'(count_inc[COUNT_W-1:8]);
                                res.byte_count  = count_inc;
                                res.sysex_byte  = b;
                                res.last        = sx_last;
                                if (sx_last)
                                begin
                                    delta_next = '0;
                                    phase_next = (rem_dec == '0) ? PH_DONE : PH_DELTA;
                                end
                            end
                        endcase
                    end
                end
            endcase
        end
        res.timestamp = time_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg      <= 8'd12;
            pos_reg         <= '0;
            time_reg        <= '0;
            z_reg           <= 1'b0;
            rem_reg         <= '0;
            phase_reg       <= PH_IDLE;
            held_status_reg <= '0;
            held_data_reg   <= '0;
            wanted_reg      <= '0;
            delta_reg       <= '0;
            count_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                offset_reg <= cfg_data;
            end
            pos_reg         <= pos_next;
            time_reg        <= time_next;
            z_reg           <= z_next;
            rem_reg         <= rem_next;
            phase_reg       <= phase_next;
            held_status_reg <= held_status_next;
            held_data_reg   <= held_data_next;
            wanted_reg      <= wanted_next;
            delta_reg       <= delta_next;
            count_reg       <= count_next;
        end
    end

endmodule

@@ design/rmcp_out_stage.sv @@
// Result register: holds one result item until the sink takes it.
module rmcp_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                res_valid,
    input  rmcp_pkg::out_item_t res,
    output logic                slot_free,
    output logic                out_valid,
    input  logic                out_ready,
    output rmcp_pkg::out_item_t out_item
);
    import rmcp_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    logic      load;
    out_item_t item_reg;

    assign slot_free = !valid_reg || out_ready;
    assign load      = res_valid && slot_free;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= res;
        end
    end

endmodule

@@ design/rtp_midi_command_parser_unit.sv @@
// A byte accepted into the input register is decoded from there, which loads its result item
// into the result register; the sink takes that item from the result register.
// Throughput: one byte per cycle, set by the single decode pass between input and result
// registers; a held result stalls the decode, and the input register takes one byte at most.
// Reset (rst_n, async, active low): parser idle until a packet start, section offset 12,
// both handshake stages empty.
// Top level of the RTP-MIDI command section parser.
module rtp_midi_command_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        packet_start,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  msg_type,
    output logic [4:0]  channel,
    output logic [7:0]  first_data,
    output logic [7:0]  second_data,
    output logic [12:0] byte_count,
    output logic [31:0] timestamp,
    output logic [7:0]  sysex_byte,
    output logic        last,
    output logic [1:0]  error_code
);
    import rmcp_pkg::*;

    in_item_t  in_item;
    in_item_t  item;
    logic      item_valid;
    logic      item_take;
    logic      slot_free;
    logic      res_valid;
    out_item_t res;
    out_item_t out_item;

    assign in_item.data_byte    = data_byte;
    assign in_item.packet_start = packet_start;

    rmcp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    rmcp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .slot_free  (slot_free),
        .res_valid  (res_valid),
        .res        (res)
    );

    rmcp_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .slot_free (slot_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    assign kind        = out_item.kind;
    assign msg_type    = out_item.msg_type;
    assign channel     = out_item.channel;
    assign first_data  = out_item.first_data;
    assign second_data = out_item.second_data;
    assign byte_count  = out_item.byte_count;
    assign timestamp   = out_item.timestamp;
    assign sysex_byte  = out_item.sysex_byte;
    assign last        = out_item.last;
    assign error_code  = out_item.error_code;

    // an error item carries its code and the timestamp, with no byte count or last flag
    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_ERROR |-> error_code != ERR_NONE && byte_count == '0 &&
        last == 1'b0)
        else $error("error item with payload");

    a_last_sysex: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> kind == KIND_SYSEX)
        else $error("last set outside sysex");

    a_sysex_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_SYSEX |-> byte_count != '0 &&
        byte_count <= COUNT_W'(SYSEX_MAX) && first_data == byte_count[7:0])
        else $error("sysex count out of range");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid ##1 out_valid |-> $past(item_valid))
        else $error("result without a byte");

endmodule

@@ tb/sv/rtp_midi_command_parser_unit_tb.sv @@
// Self-checking testbench for the RTP-MIDI command section parser, with a built-in parse predictor.
module rtp_midi_command_parser_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rmcp_pkg::*;

    localparam logic [7:0] RESET_OFFSET  = 8'd12;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         STUCK_LIMIT   = 2000;
    localparam int         REPORT_MAX    = 10;

    // MIDI status codes used by the predictor and the packet generator
    localparam logic [7:0] ST_NOTE_OFF     = 8'h80;
    localparam logic [7:0] ST_PROG_CHANGE  = 8'hC0;
    localparam logic [7:0] ST_CHAN_PRESS   = 8'hD0;
    localparam logic [7:0] ST_PITCH_BEND   = 8'hE0;
    localparam logic [7:0] ST_MTC_QUARTER  = 8'hF1;
    localparam logic [7:0] ST_SONG_POS     = 8'hF2;
    localparam logic [7:0] ST_SONG_SELECT  = 8'hF3;
    localparam logic [7:0] ST_UNDEF_F4     = 8'hF4;
    localparam logic [7:0] ST_UNDEF_F5     = 8'hF5;
    localparam logic [7:0] ST_TUNE_REQ     = 8'hF6;
    localparam logic [7:0] ST_CLOCK        = 8'hF8;
    localparam logic [7:0] ST_UNDEF_F9     = 8'hF9;
    localparam logic [7:0] ST_START        = 8'hFA;
    localparam logic [7:0] ST_CONTINUE     = 8'hFB;
    localparam logic [7:0] ST_STOP         = 8'hFC;
    localparam logic [7:0] ST_UNDEF_FD     = 8'hFD;
    localparam logic [7:0] ST_SENSING      = 8'hFE;
    localparam logic [7:0] ST_SYS_RESET    = 8'hFF;

    localparam logic [7:0] ONE_BYTE_CODES [7] = '{ST_TUNE_REQ, ST_CLOCK, ST_START, ST_CONTINUE,
                                                  ST_STOP, ST_SENSING, ST_SYS_RESET};
    localparam logic [7:0] COMMON_CODES [3]   = '{ST_MTC_QUARTER, ST_SONG_POS, ST_SONG_SELECT};
    localparam logic [7:0] UNDEF_CODES [5]    = '{ST_UNDEF_F4, ST_UNDEF_F5, SYSEX_END,
                                                  ST_UNDEF_F9, ST_UNDEF_FD};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_data = 8'h00;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        packet_start = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  msg_type;
    logic [4:0]  channel;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [12:0] byte_count;
    logic [31:0] timestamp;
    logic [7:0]  sysex_byte;
    logic        last;
    logic [1:0]  error_code;

    rtp_midi_command_parser_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .packet_start (packet_start),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .msg_type     (msg_type),
        .channel      (channel),
        .first_data   (first_data),
        .second_data  (second_data),
        .byte_count   (byte_count),
        .timestamp    (timestamp),
        .sysex_byte   (sysex_byte),
        .last         (last),
        .error_code   (error_code)
    );

    // predictor state
    logic [7:0]          offset_shadow = RESET_OFFSET;
    logic [POS_W-1:0]    byte_index = '0;
    logic [31:0]         rtp_time = '0;
    logic [7:0]          section_flags = '0;
    logic [REM_W-1:0]    section_left = '0;
    phase_t              parse_state = PH_IDLE;
    logic [7:0]          pending_status = '0;
    logic [7:0]          pending_data1 = '0;
    logic [1:0]          data_left = '0;
    logic [2:0]          delta_len = '0;
    logic [COUNT_W-1:0]  sysex_taken = '0;

    out_item_t pending_results[$];
    int        fail_count = 0;
    int        stuck_cycles = 0;
    int        bytes_sent = 0;
    int        send_idle_pct = 0;
    int        stall_pct = 0;

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    function automatic logic [2:0] status_len(input logic [7:0] s);
        if (!s[7])
            return LEN_UNDEF;
        if (s < SYSEX_START)
            return (s[7:4] == ST_PROG_CHANGE[7:4] || s[7:4] == ST_CHAN_PRESS[7:4]) ?
                   LEN_TWO : LEN_THREE;
        case (s)
            SYSEX_START:                    return LEN_SYSEX;
            ST_MTC_QUARTER, ST_SONG_SELECT: return LEN_TWO;
            ST_SONG_POS:                    return LEN_THREE;
            ST_TUNE_REQ, ST_CLOCK, ST_START, ST_CONTINUE,
            ST_STOP, ST_SENSING, ST_SYS_RESET: return LEN_ONE;
            default:                        return LEN_UNDEF;
        endcase
    endfunction

    function automatic out_item_t form_result(input logic [1:0] k, input logic [7:0] t,
                                              input logic [4:0] ch, input logic [7:0] d1,
                                              input logic [7:0] d2, input logic [12:0] cnt,
                                              input logic [7:0] sx, input logic lst,
                                              input logic [1:0] err);
        out_item_t r;
        r.kind        = k;
        r.msg_type    = t;
        r.channel     = ch;
        r.first_data  = d1;
        r.second_data = d2;
        r.byte_count  = cnt;
        r.timestamp   = rtp_time;
        r.sysex_byte  = sx;
        r.last        = lst;
        r.error_code  = err;
        return r;
    endfunction

    function automatic void finish_command();
        delta_len   = '0;
        parse_state = (section_left == 0) ? PH_DONE : PH_DELTA;
    endfunction

    function automatic void open_section();
        if (section_left == 0)
            parse_state = PH_DONE;
        else if (section_flags[5])
        begin
            delta_len   = '0;
            parse_state = PH_DELTA;
        end
        else
            parse_state = PH_STATUS;
    endfunction

    function automatic out_item_t abort_packet(input logic [1:0] code);
        parse_state = PH_DONE;
        return form_result(KIND_ERROR, 8'h00, 5'd0, 8'h00, 8'h00, '0, 8'h00, 1'b0, code);
    endfunction

    function automatic out_item_t short_message(input logic [7:0] s, input logic [2:0] n,
                                                input logic [7:0] d1, input logic [7:0] d2);
        out_item_t r;
        logic      chan_msg;
        chan_msg = (s < SYSEX_START);
        r = form_result(KIND_SHORT, chan_msg ? {s[7:4], 4'h0} : s,
                        chan_msg ? {1'b0, s[3:0]} + 5'd1 : 5'd0,
                        (n >= LEN_TWO) ? d1 : 8'h00, (n == LEN_THREE) ? d2 : 8'h00,
                        {10'd0, n}, 8'h00, 1'b0, ERR_NONE);
        finish_command();
        return r;
    endfunction

    function automatic out_item_t take_sysex(input logic [7:0] b);
        out_item_t r;
        logic      lst;
        sysex_taken = sysex_taken + 1'b1;
        lst = (b == SYSEX_END && sysex_taken > 1) || sysex_taken >= SYSEX_MAX ||
              section_left == 0;
        r = form_result(KIND_SYSEX, SYSEX_START, 5'd0, sysex_taken[7:0],
                        {3'd0, sysex_taken[12:8]}, sysex_taken, b, lst, ERR_NONE);
        if (lst)
            finish_command();
        else
            parse_state = PH_SYSEX;
        return r;
    endfunction

    // Advances the predictor by one packet byte; returns 1 when the byte yields a result.
    function automatic bit parse_byte(input logic [7:0] b, input logic first,
                                      output out_item_t r);
        logic [POS_W-1:0] p;
        logic [2:0]       n;
        r = '0;
        if (first)
        begin
            byte_index     = '0;
            rtp_time       = '0;
            section_flags  = '0;
            section_left   = '0;
            pending_status = '0;
            pending_data1  = '0;
            data_left      = '0;
            delta_len      = '0;
            sysex_taken    = '0;
            parse_state    = PH_HEADER;
        end
        if (parse_state == PH_IDLE)
            return 1'b0;

        p = byte_index;
        if (byte_index != '1)
            byte_index = byte_index + 1'b1;
        if (p >= 4 && p <= 7)
            rtp_time = {rtp_time[23:0], b};

        case (parse_state)
            PH_HEADER:
            begin
                if (p == {8'h00, offset_shadow})
                begin
                    section_flags = b;
                    section_left  = {8'h00, b[3:0]};
                    if (b[7])
                        parse_state = PH_LENLO;
                    else
                        open_section();
                end
                return 1'b0;
            end
            PH_LENLO:
            begin
                section_left = {section_left[3:0], b};
                open_section();
                return 1'b0;
            end
            PH_DONE:
                return 1'b0;
            default:
                ;
        endcase

        if (section_left == 0)
        begin
            parse_state = PH_DONE;
            return 1'b0;
        end
        section_left = section_left - 1'b1;

        case (parse_state)
            PH_DELTA:
            begin
                delta_len = delta_len + 1'b1;
                if (!b[7] || delta_len >= 4)
                begin
                    parse_state = (section_left == 0) ? PH_DONE : PH_STATUS;
                    return 1'b0;
                end
                if (section_left == 0)
                begin
                    r = abort_packet(ERR_OVERRUN);
                    return 1'b1;
                end
                return 1'b0;
            end
            PH_STATUS:
            begin
                n = status_len(b);
                if (n == LEN_UNDEF)
                    r = abort_packet(ERR_UNDEF);
                else if (n == LEN_ONE)
                    r = short_message(b, LEN_ONE, 8'h00, 8'h00);
                else if (n == LEN_SYSEX)
                begin
                    sysex_taken = '0;
                    r = take_sysex(b);
                end
                else if (section_left == 0)
                    r = abort_packet(ERR_OVERRUN);
                else
                begin
                    pending_status = b;
                    data_left      = 2'(n - 1);
                    parse_state    = PH_DATA;
                    return 1'b0;
                end
                return 1'b1;
            end
            PH_DATA:
            begin
                n = status_len(pending_status);
                if (n == LEN_THREE && data_left == 2)
                begin
                    pending_data1 = b;
                    data_left     = 2'd1;
                    if (section_left == 0)
                    begin
                        r = abort_packet(ERR_OVERRUN);
                        return 1'b1;
                    end
                    return 1'b0;
                end
                data_left = 2'd0;
                if (n == LEN_THREE)
                    r = short_message(pending_status, LEN_THREE, pending_data1, b);
                else
                    r = short_message(pending_status, LEN_TWO, b, 8'h00);
                return 1'b1;
            end
            PH_SYSEX:
            begin
                r = take_sysex(b);
                return 1'b1;
            end
            default:
            begin
                parse_state = PH_DONE;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic void check_field(input string field_name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            if (fail_count < REPORT_MAX)
                $display("%0t: %s expected %0h, got %0h", $time, field_name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin : scoreboard
        out_item_t want;
        if (rst_n)
        begin
            if (cfg_we)
                offset_shadow = cfg_data;
            if (in_valid && in_ready)
            begin
                if (parse_byte(data_byte, packet_start, want))
                    pending_results.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    if (fail_count < REPORT_MAX)
                        $display("%0t: unexpected result, kind %0d", $time, kind);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("kind", 32'(want.kind), 32'(kind));
                    check_field("msg_type", 32'(want.msg_type), 32'(msg_type));
                    check_field("channel", 32'(want.channel), 32'(channel));
                    check_field("first_data", 32'(want.first_data), 32'(first_data));
                    check_field("second_data", 32'(want.second_data), 32'(second_data));
                    check_field("byte_count", 32'(want.byte_count), 32'(byte_count));
                    check_field("timestamp", want.timestamp, timestamp);
                    check_field("sysex_byte", 32'(want.sysex_byte), 32'(sysex_byte));
                    check_field("last", 32'(want.last), 32'(last));
                    check_field("error_code", 32'(want.error_code), 32'(error_code));
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stuck_cycles = 0;
            else
            begin
                stuck_cycles++;
                if (stuck_cycles >= STUCK_LIMIT)
                begin
                    $display("%0t: no item moved for %0d cycles", $time, STUCK_LIMIT);
                    $display("rtp_midi_command_parser_unit regression: fail");
                    $finish;
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic first);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        data_byte    <= value;
        packet_start <= first;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // waits for the parser to drain before touching the offset register
    task automatic write_offset(input logic [7:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_random_packet();
        logic [7:0] body[$];
        logic [7:0] st;
        logic [7:0] prefix;
        int         sect_len;
        int         n_cmds;
        int         n_data;
        int         pick;
        int         ofs;
        bit         has_z;
        bit         has_b;
        has_z  = 1'($urandom);
        n_cmds = $urandom_range(0, 5);
        for (int c = 0; c < n_cmds; c++)
        begin
            if (c > 0 || has_z)
            begin
                // varint delta; now and then the last octet keeps its continuation bit
                n_data = $urandom_range(1, 4);
                for (int d = 0; d < n_data; d++)
                    body.push_back((d < n_data - 1 || $urandom_range(0, 9) == 0) ?
                                   8'($urandom_range(128, 255)) : 8'($urandom_range(0, 127)));
            end
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                st = {4'($urandom_range(ST_NOTE_OFF[7:4], ST_PITCH_BEND[7:4])), 4'($urandom)};
                n_data = int'(status_len(st)) - 1;
            end
            else if (pick < 57)
            begin
                st = COMMON_CODES[$urandom_range(0, 2)];
                n_data = int'(status_len(st)) - 1;
            end
            else if (pick < 70)
            begin
                st = ONE_BYTE_CODES[$urandom_range(0, 6)];
                n_data = 0;
            end
            else if (pick < 88)
            begin
                st = SYSEX_START;
                n_data = ($urandom_range(0, 9) == 0) ?
                         $urandom_range(SYSEX_MAX - 3, SYSEX_MAX + 4) : $urandom_range(0, 8);
            end
            else
            begin
                st = ($urandom_range(0, 1) == 0) ? UNDEF_CODES[$urandom_range(0, 4)] :
                     8'($urandom_range(0, 127));
                n_data = 0;
            end
            body.push_back(st);
            for (int d = 0; d < n_data; d++)
                body.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom) :
                               8'($urandom_range(0, 127)));
            if (st == SYSEX_START && $urandom_range(0, 4) != 0)
                body.push_back(SYSEX_END);
        end

        // mostly exact lengths; some cut the section short, some run past the packet
        sect_len = body.size();
        pick = $urandom_range(0, 99);
        if (pick < 12)
            sect_len = $urandom_range(0, sect_len);
        else if (pick < 22)
            sect_len = sect_len + $urandom_range(1, 3);
        else if (pick < 24)
            sect_len = 4095;
        has_b = (sect_len > 15) || ($urandom_range(0, 3) == 0);

        if ($urandom_range(0, 11) == 0)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);

        ofs = int'(offset_shadow);
        for (int i = 0; i < ofs; i++)
        begin
            pick   = $urandom_range(0, 9);
            prefix = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
            send_byte(prefix, i == 0);
        end
        send_byte({has_b, 1'($urandom), has_z, 1'($urandom),
                   has_b ? 4'(sect_len >> 8) : 4'(sect_len)}, ofs == 0);
        if (has_b)
            send_byte(8'(sect_len), 1'b0);
        foreach (body[i])
            send_byte(body[i], 1'b0);
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom), 1'b0);
    endtask

    task automatic run_packets(input int quota);
        int goal;
        goal = bytes_sent + quota;
        while (bytes_sent < goal)
            send_random_packet();
    endtask

    task automatic test_directed_cases();
        write_offset(8'h00);
        send_idle_pct = 0;
        stall_pct     = 0;
        send_byte(8'h55, 1'b0);            // no packet open yet
        send_byte(8'h00, 1'b1);            // empty section
        send_byte(ST_NOTE_OFF, 1'b0);
        send_byte(8'hA0, 1'b1);            // long length form, delta before first command
        send_byte(8'h09, 1'b0);
        repeat (4) send_byte(8'hFF, 1'b0); // delta stops after four octets
        send_byte(ST_PROG_CHANGE | 8'h05, 1'b0);
        send_byte(8'h80, 1'b0);            // data byte with high bit
        send_byte(8'h00, 1'b0);
        send_byte(ST_UNDEF_F4, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h06, 1'b1);
        send_byte(SYSEX_START, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(SYSEX_END, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(ST_PITCH_BEND, 1'b0);
        send_byte(8'h7F, 1'b0);            // section ends mid message
        send_byte(8'h01, 1'b1);
        send_byte(ST_MTC_QUARTER, 1'b0);
        send_byte(8'h04, 1'b1);
        send_byte(ST_CLOCK, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(SYSEX_START, 1'b0);
        send_byte(8'hFF, 1'b0);            // sysex closed by section end
    endtask

    task automatic test_no_idling();
        write_offset(RESET_OFFSET);
        send_idle_pct = 0;
        stall_pct     = 0;
        run_packets(180);
    endtask

    task automatic test_sender_gaps();
        write_offset(8'd3);                // header just before the timestamp bytes
        send_idle_pct = 68;
        stall_pct     = 0;
        run_packets(180);
    endtask

    task automatic test_receiver_stalls();
        write_offset(8'($urandom_range(8, 40)));
        send_idle_pct = 0;
        stall_pct     = 68;
        run_packets(180);
    endtask

    task automatic test_both_sides_idle();
        write_offset(8'($urandom_range(0, 20)));
        send_idle_pct = 26;
        stall_pct     = 26;
        run_packets(180);
    endtask

    task automatic test_highest_offset();
        write_offset(8'hFF);
        send_idle_pct = 26;
        stall_pct     = 26;
        run_packets(200);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_cases();
        test_no_idling();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_sides_idle();
        test_highest_offset();

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("rtp_midi_command_parser_unit regression: pass");
        else
            $display("rtp_midi_command_parser_unit regression: fail");
        $finish;
    end

endmodule
